@@ sv/pcpq_pkg.sv @@
package pcpq_pkg;
    localparam int DEPTH_DEF = 16;

    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_CONSUME = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] CFG_PEER_CAP = 2'd0;
    localparam logic [1:0] CFG_NO_PEER  = 2'd1;
    localparam logic [1:0] CFG_TAG_MASK = 2'd2;

    localparam logic [4:0]  PEER_CAP_RST = 5'd4;
    localparam logic [15:0] NO_PEER_RST  = 16'hFFFF;
    localparam logic [7:0]  TAG_MASK_RST = 8'h80;

    // One classified command, as passed from front to back.
    typedef struct packed {
        logic [1:0]  kind;
        logic        push_ok;
        logic [15:0] handle;
        logic [15:0] length;
        logic [31:0] seen_time;
        logic [15:0] peer;
        logic        capped;
        logic [23:0] tag;
        logic [7:0]  refs;
        logic [7:0]  flags;
        logic [7:0]  index;
    } cmd_t;

    // One result transaction.
    typedef struct packed {
        logic        ok;
        logic        released;
        logic [15:0] handle_out;
        logic [15:0] length_out;
        logic [31:0] seen_time_out;
        logic [15:0] peer_out;
        logic [23:0] tag_out;
        logic [7:0]  refs_out;
        logic [7:0]  flags_out;
        logic        last;
    } res_t;
endpackage

@@ sv/pcpq_front.sv @@
// Front: takes input transactions, applies config, builds commands.
module pcpq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           kind,
    input  logic                 handle_present,
    input  logic [15:0]          buffer_handle,
    input  logic [15:0]          length,
    input  logic [31:0]          timestamp,
    input  logic [15:0]          peer,
    input  logic                 tag_present,
    input  logic [23:0]          tag,
    input  logic [7:0]           ref_count,
    input  logic [7:0]           flag_bits,
    input  logic [7:0]           index,
    input  logic [7:0]           tag_flag_mask,
    input  logic [15:0]          no_peer_id,
    output logic                 cmd_valid,
    output pcpq_pkg::cmd_t       cmd,
    input  logic                 cmd_take
);
    import pcpq_pkg::*;

    // Two-entry command queue.
    cmd_t       q_reg [2];
    logic       rd_ptr_reg, wr_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       wr, rd;

    always_comb
    begin
        c           = '0;
        c.kind      = kind;
        c.push_ok   = handle_present && (length != 16'd0);
        c.handle    = buffer_handle;
        c.length    = length;
        c.seen_time = timestamp;
        c.peer      = peer;
        c.capped    = (peer != no_peer_id);
        c.tag       = tag_present ? tag : 24'd0;
        c.refs      = (ref_count != 8'd0) ? ref_count : 8'd1;
        c.flags     = tag_present ? (flag_bits | tag_flag_mask) : flag_bits;
        c.index     = index;
    end

    assign full      = (cnt_reg == 2'd2);
    assign wr        = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign rd        = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wr_ptr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr) wr_ptr_reg <= ~wr_ptr_reg;
            if (rd) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

@@ sv/pcpq_back.sv @@
// Back: owns the entry store and sequences each command.
module pcpq_back #(
    parameter int DEPTH = pcpq_pkg::DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  pcpq_pkg::cmd_t       cmd,
    output logic                 cmd_take,
    input  logic [4:0]           peer_cap,
    output logic                 res_valid,
    output pcpq_pkg::res_t       res,
    output logic [CW-1:0]        held,
    output logic [31:0]          drops,
    input  logic                 res_take
);
    import pcpq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_APPND = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_READ  = 3'd6;

    // Entry store, shifted in place.
    logic [15:0] e_handle [DEPTH];
    logic [15:0] e_length [DEPTH];
    logic [31:0] e_time   [DEPTH];
    logic [15:0] e_peer   [DEPTH];
    logic [23:0] e_tag    [DEPTH];
    logic [7:0]  e_refs   [DEPTH];
    logic [7:0]  e_flags  [DEPTH];

    logic [2:0]    state_reg;
    cmd_t          cmd_reg;
    logic [CW-1:0] held_reg;
    logic [31:0]   drops_reg;
    logic [CW-1:0] pos_reg;       // scan / shift / flush pointer
    logic [CW-1:0] pcnt_reg;      // peer hits
    logic [CW-1:0] oldest_reg;
    logic          have_reg;
    logic          append_reg;    // push continues with append after shift
    logic [CW-1:0] flush_cnt_reg; // entries being flushed
    res_t          res_reg;
    res_t          res_first;     // first result of a new command

    logic [AW-1:0] pa, pn;
    logic [CW-1:0] idx_w;
    assign pa    = pos_reg[AW-1:0];
    assign pn    = AW'(pos_reg + 1'b1);
    assign idx_w = (cmd.index > 8'(DEPTH)) ? CW'(DEPTH) : CW'(cmd.index);

    assign cmd_take  = (state_reg == S_IDLE) && cmd_valid;
    assign res_valid = (state_reg == S_OUT);
    assign res       = res_reg;
    assign held      = held_reg;
    assign drops     = drops_reg;

    always_comb
    begin
        res_first      = '0;
        res_first.last = 1'b1;
        case (cmd.kind)
            KIND_PUSH:
            begin
                res_first.ok = cmd.push_ok && (held_reg < CW'(DEPTH));
            end
            KIND_CONSUME:
            begin
                if (idx_w < held_reg)
                begin
                    res_first.ok = 1'b1;
                    if (e_refs[idx_w[AW-1:0]] <= 8'd1)
                    begin
                        res_first.released   = 1'b1;
                        res_first.handle_out = e_handle[idx_w[AW-1:0]];
                    end
                end
            end
            KIND_READ:
            begin
                res_first.ok = 1'b0;
            end
            default:
            begin
                res_first.ok = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && cmd.kind == KIND_CONSUME && idx_w < held_reg
                    && e_refs[idx_w[AW-1:0]] > 8'd1)
                begin
                    e_refs[idx_w[AW-1:0]] <= e_refs[idx_w[AW-1:0]] - 8'd1;
                end
            end
            S_SHIFT:
            begin
                if (pos_reg + 1'b1 < held_reg)
                begin
                    e_handle[pa] <= e_handle[pn];
                    e_length[pa] <= e_length[pn];
                    e_time[pa]   <= e_time[pn];
                    e_peer[pa]   <= e_peer[pn];
                    e_tag[pa]    <= e_tag[pn];
                    e_refs[pa]   <= e_refs[pn];
                    e_flags[pa]  <= e_flags[pn];
                end
            end
            S_APPND:
            begin
                e_handle[held_reg[AW-1:0]] <= cmd_reg.handle;
                e_length[held_reg[AW-1:0]] <= cmd_reg.length;
                e_time[held_reg[AW-1:0]]   <= cmd_reg.seen_time;
                e_peer[held_reg[AW-1:0]]   <= cmd_reg.peer;
                e_tag[held_reg[AW-1:0]]    <= cmd_reg.tag;
                e_refs[held_reg[AW-1:0]]   <= cmd_reg.refs;
                e_flags[held_reg[AW-1:0]]  <= cmd_reg.flags;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            drops_reg     <= '0;
            pos_reg       <= '0;
            pcnt_reg      <= '0;
            oldest_reg    <= '0;
            have_reg      <= 1'b0;
            append_reg    <= 1'b0;
            flush_cnt_reg <= '0;
            cmd_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg       <= cmd;
                        res_reg       <= res_first;
                        pos_reg       <= (cmd.kind inside {KIND_CONSUME, KIND_READ})
                                         ? idx_w : '0;
                        pcnt_reg      <= '0;
                        have_reg      <= 1'b0;
                        append_reg    <= 1'b0;
                        flush_cnt_reg <= held_reg;
                        case (cmd.kind)
                            KIND_PUSH:
                            begin
                                if (cmd.push_ok && held_reg < CW'(DEPTH))
                                begin
                                    append_reg <= 1'b1;
                                    state_reg  <= cmd.capped ? S_SCAN : S_APPND;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            KIND_CONSUME:
                            begin
                                if (idx_w < held_reg && e_refs[idx_w[AW-1:0]] <= 8'd1)
                                begin
                                    state_reg <= S_SHIFT;
                                end
                                else
                                begin
                                    state_reg <= S_OUT;
                                end
                            end
                            KIND_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                if (held_reg == '0)
                                begin
                                    state_reg <= S_OUT;
                                end
                                else
                                begin
                                    // queue is empty from the first flush result on
                                    held_reg  <= '0;
                                    state_reg <= S_FLUSH;
                                end
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (pos_reg < held_reg)
                    begin
                        res_reg.ok            <= 1'b1;
                        res_reg.handle_out    <= e_handle[pa];
                        res_reg.length_out    <= e_length[pa];
                        res_reg.seen_time_out <= e_time[pa];
                        res_reg.peer_out      <= e_peer[pa];
                        res_reg.tag_out       <= e_tag[pa];
                        res_reg.refs_out      <= e_refs[pa];
                        res_reg.flags_out     <= e_flags[pa];
                    end
                    state_reg <= S_OUT;
                end
                S_SCAN:
                begin
                    if (pos_reg < held_reg)
                    begin
                        if (e_peer[pa] == cmd_reg.peer)
                        begin
                            pcnt_reg <= pcnt_reg + 1'b1;
                            if (!have_reg)
                            begin
                                have_reg   <= 1'b1;
                                oldest_reg <= pos_reg;
                            end
                        end
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else if (have_reg && 6'(pcnt_reg) >= 6'(peer_cap))
                    begin
                        res_reg.released   <= 1'b1;
                        res_reg.handle_out <= e_handle[oldest_reg[AW-1:0]];
                        drops_reg <= drops_reg + 32'd1;
                        pos_reg   <= oldest_reg;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        state_reg <= S_APPND;
                    end
                end
                S_SHIFT:
                begin
                    if (pos_reg + 1'b1 < held_reg)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        held_reg  <= held_reg - 1'b1;
                        state_reg <= append_reg ? S_APPND : S_OUT;
                    end
                end
                S_APPND:
                begin
                    held_reg  <= held_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_FLUSH:
                begin
                    res_reg   <= '{ok: 1'b1, released: 1'b1, handle_out: e_handle[pa],
                                   last: (pos_reg + 1'b1 == flush_cnt_reg), default: '0};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_take)
                    begin
                        if (cmd_reg.kind == KIND_FLUSH && !res_reg.last)
                        begin
                            pos_reg   <= pos_reg + 1'b1;
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/peer_capped_packet_queue_core.sv @@
// Peer-capped packet-descriptor queue.
// A reject, refs decrement or empty flush goes from accept straight to S_OUT; a read
// passes through S_READ and an uncapped push through S_APPND; a capped push scans every
// held entry, and an eviction or removal shifts the tail one entry per cycle. A flush
// visits S_FLUSH and S_OUT per entry. One item at a time; the next waits for the last pop.
// Reset (rst_n, async low) empties the queue, zeroes the drop counter and loads default
// config; entry storage is not cleared.
module peer_capped_packet_queue_core #(
    parameter int DEPTH = pcpq_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input transactions
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic        handle_present,
    input  logic [15:0] buffer_handle,
    input  logic [15:0] length,
    input  logic [31:0] timestamp,
    input  logic [15:0] peer,
    input  logic        tag_present,
    input  logic [23:0] tag,
    input  logic [7:0]  ref_count,
    input  logic [7:0]  flag_bits,
    input  logic [7:0]  index,
    // result transactions
    output logic        empty,
    input  logic        pop,
    output logic        ok,
    output logic        released,
    output logic [15:0] handle_out,
    output logic [15:0] length_out,
    output logic [31:0] seen_time_out,
    output logic [15:0] peer_out,
    output logic [23:0] tag_out,
    output logic [7:0]  refs_out,
    output logic [7:0]  flags_out,
    output logic [4:0]  occupancy,
    output logic [31:0] drop_count,
    output logic        last
);
    import pcpq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [4:0]  peer_cap_reg;
    logic [15:0] no_peer_reg;
    logic [7:0]  tag_mask_reg;

    // config registers; out-of-list index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_cap_reg <= PEER_CAP_RST;
            no_peer_reg  <= NO_PEER_RST;
            tag_mask_reg <= TAG_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEER_CAP: peer_cap_reg <= cfg_data[4:0];
                CFG_NO_PEER:  no_peer_reg  <= cfg_data;
                CFG_TAG_MASK: tag_mask_reg <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    logic          cmd_valid, cmd_take, res_valid;
    cmd_t          cmd;
    res_t          res;
    logic [CW-1:0] held;

    pcpq_front u_front (
        .clk, .rst_n, .push, .full, .kind, .handle_present, .buffer_handle,
        .length, .timestamp, .peer, .tag_present, .tag, .ref_count,
        .flag_bits, .index,
        .tag_flag_mask (tag_mask_reg),
        .no_peer_id    (no_peer_reg),
        .cmd_valid, .cmd, .cmd_take
    );

    pcpq_back #(.DEPTH(DEPTH)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd, .cmd_take,
        .peer_cap (peer_cap_reg),
        .res_valid, .res, .held,
        .drops    (drop_count),
        .res_take (pop)
    );

    // result register in the back stays put until popped
    assign empty         = !res_valid;
    assign ok            = res.ok;
    assign released      = res.released;
    assign handle_out    = res.handle_out;
    assign length_out    = res.length_out;
    assign seen_time_out = res.seen_time_out;
    assign peer_out      = res.peer_out;
    assign tag_out       = res.tag_out;
    assign refs_out      = res.refs_out;
    assign flags_out     = res.flags_out;
    assign occupancy     = 5'(held);
    assign last          = res.last;
endmodule

@@ sv/pcpq_checker.sv @@
module pcpq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        released,
    input logic        ok,
    input logic [15:0] handle_out,
    input logic [4:0]  occupancy,
    input logic [31:0] drop_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(handle_out)))
        else $error("result changed while stalled");
    a_drops: assert property (@(posedge clk) disable iff (!rst_n)
        $changed(drop_count) |-> (drop_count == $past(drop_count) + 32'd1))
        else $error("drop count jumped");
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= 5'd16)
        else $error("occupancy out of range");
    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && released) |-> ok)
        else $error("release without ok");
endmodule

bind peer_capped_packet_queue_core pcpq_checker u_chk (
    .clk, .rst_n, .empty, .pop, .released, .ok, .handle_out, .occupancy,
    .drop_count
);
